[rtl/smr_pkg.sv]
package smr_pkg;

  // mix buffer geometry, depth is a power of two
  localparam int AddrW       = 16;
  localparam int BufferDepth = 1 << AddrW;
  localparam int SampleW     = 16;

  // clip limits, full negative scale is never stored
  localparam logic signed [SampleW-1:0] MixMax = 16'sd32767;
  localparam logic signed [SampleW-1:0] MixMin = -16'sd32767;

  // item commands
  localparam logic CmdMix  = 1'b0;
  localparam logic CmdRead = 1'b1;

  typedef logic [AddrW-1:0]          addr_t;
  typedef logic signed [SampleW-1:0] sample_t;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic exec;
  } smr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
  } smr_sts_t;

  // saturating add of two samples
  function automatic sample_t clip_sum(sample_t a, sample_t b);
    logic signed [SampleW:0] s;
    s = {a[SampleW-1], a} + {b[SampleW-1], b};
    if (s > $signed({MixMax[SampleW-1], MixMax})) begin
      return MixMax;
    end else if (s < $signed({MixMin[SampleW-1], MixMin})) begin
      return MixMin;
    end
    return s[SampleW-1:0];
  endfunction

endpackage

[rtl/smr_ram.sv]
module smr_ram #(
  parameter int Width = 16,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/smr_ctrl.sv]
module smr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  smr_pkg::smr_sts_t sts_i,
  output smr_pkg::smr_cmd_t cmd_o,
  output logic              busy
);

  typedef enum logic [2:0] {
    StClear = 3'b001,
    StIdle  = 3'b010,
    StExec  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: begin
        if (sts_i.clr_done) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  // commands to the datapath
  assign cmd_o.clr_wr = (state_q == StClear);
  assign cmd_o.accept = (state_q == StIdle) && start;
  assign cmd_o.exec   = (state_q == StExec);
  assign busy         = (state_q != StIdle);

endmodule

[rtl/smr_datapath.sv]
module smr_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smr_pkg::smr_cmd_t cmd_i,
  output smr_pkg::smr_sts_t sts_o,
  input  logic              command_i,
  input  logic [15:0]       offset_i,
  input  logic signed [15:0] sample_i,
  output logic signed [15:0] read_sample_o,
  output logic              read_valid_o
);

  smr_pkg::addr_t   pos_q, pos_d;
  smr_pkg::addr_t   clr_q;
  smr_pkg::addr_t   addr_q, addr_d;
  logic             cmd_q;
  smr_pkg::sample_t sample_q;
  smr_pkg::sample_t out_q;
  logic             valid_q;

  logic             wr_en;
  smr_pkg::addr_t   wr_addr;
  smr_pkg::sample_t wr_data;
  logic [15:0]      rd_data;

  // entry address: play position, plus offset for a mix
  always_comb begin
    if (command_i == smr_pkg::CmdRead) begin
      addr_d = pos_q;
    end else begin
      addr_d = pos_q + smr_pkg::addr_t'(offset_i);
    end
  end

  // write port: clearing sweep, or write back of the executing item
  always_comb begin
    wr_en   = cmd_i.clr_wr || cmd_i.exec;
    wr_addr = cmd_i.clr_wr ? clr_q : addr_q;
    wr_data = '0;
    if (cmd_i.exec && (cmd_q == smr_pkg::CmdMix)) begin
      wr_data = smr_pkg::clip_sum(smr_pkg::sample_t'(rd_data), sample_q);
    end
  end

  assign pos_d = (cmd_i.exec && (cmd_q == smr_pkg::CmdRead)) ? pos_q + 1'b1 : pos_q;

  smr_ram #(
    .Width (smr_pkg::SampleW),
    .Depth (smr_pkg::BufferDepth)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd_i.accept),
    .rd_addr_i (addr_d),
    .rd_data_o (rd_data)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      clr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      valid_q <= cmd_i.exec && (cmd_q == smr_pkg::CmdRead);
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      addr_q   <= addr_d;
      cmd_q    <= command_i;
      sample_q <= sample_i;
    end
    if (cmd_i.exec) begin
      out_q <= smr_pkg::sample_t'(rd_data);
    end
  end

  assign sts_o.clr_done = (clr_q == {smr_pkg::AddrW{1'b1}});
  assign read_sample_o  = out_q;
  assign read_valid_o   = valid_q;

endmodule

[rtl/saturating_audio_mix_ring_top.sv]
// channel   signals                                   transfer when
// item in   start, command_i, offset_i, sample_i      start && !busy at clk_i edge
// result    read_valid_o, read_sample_o               read_valid_o high, one cycle
//
// an item is handled as an entry read from the mix memory, then clip and write back
// a read's result shows in the cycle after its write back, while the next item may already be taken
// after reset a clearing sweep writes zero to all 65536 entries, with busy high
// rst_ni is asynchronous, active low; the result side has no back-pressure
module saturating_audio_mix_ring_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               command_i,
  input  logic [15:0]        offset_i,
  input  logic signed [15:0] sample_i,
  output logic               read_valid_o,
  output logic signed [15:0] read_sample_o
);

  smr_pkg::smr_cmd_t cmd;
  smr_pkg::smr_sts_t sts;

  smr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  smr_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .command_i     (command_i),
    .offset_i      (offset_i),
    .sample_i      (sample_i),
    .read_sample_o (read_sample_o),
    .read_valid_o  (read_valid_o)
  );

  // a result follows an executing item
  a_valid_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_valid_o |-> $past(cmd.exec))
    else $error("result strobe without an executing item");

  // clipping keeps negative full scale out of the buffer
  a_no_neg_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_valid_o |-> (read_sample_o != 16'sh8000))
    else $error("negative full scale read out");

  // an accepted item occupies the block in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && cmd.exec))
    else $error("accepted item not executing");

  // results never come back to back
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_valid_o |=> !read_valid_o)
    else $error("result strobes in consecutive cycles");

endmodule
